// File: sv/sbof_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbof_pkg
// Widths, types and helpers shared by the segment / box overlap fraction unit.
// ----------------------------------------------------------------------------
package sbof_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int FRAC_BITS   = 16;

	// Coordinate difference, product of two differences, divider operand.
	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW;
	localparam int NW = 2 * COORD_WIDTH;
	localparam int QW = FRAC_BITS + 1;

	localparam int IN_W  = ((8 * COORD_WIDTH + 7) / 8) * 8;
	localparam int OUT_W = ((QW + 7) / 8) * 8;

	localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

	typedef enum logic [1:0] {
		K_ZERO,
		K_ONE,
		K_DIV
	} kind_t;

	// Everything the geometry front end hands to case selection.
	typedef struct packed {
		logic                   ia;
		logic                   ib;
		logic [3:0]             cut;
		logic [3:0][DW-1:0]     cn;
		logic [3:0][DW-1:0]     cd;
		logic [DW-1:0]          one_num;
		logic [DW-1:0]          one_den;
		logic [1:0][DW-1:0]     hml;
		logic [1:0][DW-1:0]     absd;
	} front_t;

	// One division job.
	typedef struct packed {
		kind_t         kind;
		logic [NW-1:0] num;
		logic [NW-1:0] den;
	} div_t;

	function automatic logic signed [DW-1:0] sx(input logic signed [COORD_WIDTH-1:0] v);
		return {v[COORD_WIDTH-1], v};
	endfunction

	function automatic logic signed [PW:0] sxp(input logic signed [PW-1:0] v);
		return {v[PW-1], v};
	endfunction

endpackage
`default_nettype wire

// File: sv/sbof_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbof_front
// Three stages: differences and inside tests, edge products, crossing flags.
// ----------------------------------------------------------------------------
module sbof_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       vin,
	input  wire logic [sbof_pkg::IN_W-1:0]  data,
	output logic                            vout,
	output sbof_pkg::front_t                fr
);

	localparam int CW = sbof_pkg::COORD_WIDTH;
	localparam int DW = sbof_pkg::DW;
	localparam int PW = sbof_pkg::PW;

	logic signed [CW-1:0] pa [2];
	logic signed [CW-1:0] pb [2];
	logic signed [CW-1:0] plo [2];
	logic signed [CW-1:0] phi [2];

	assign pa[0]  = data[0*CW +: CW];
	assign pa[1]  = data[1*CW +: CW];
	assign pb[0]  = data[2*CW +: CW];
	assign pb[1]  = data[3*CW +: CW];
	assign plo[0] = data[4*CW +: CW];
	assign plo[1] = data[5*CW +: CW];
	assign phi[0] = data[6*CW +: CW];
	assign phi[1] = data[7*CW +: CW];

	logic v_s1, v_s2;

	// Stage 1 registers.
	logic                 ia_s1, ib_s1;
	logic signed [DW-1:0] delta_s1 [2];
	logic signed [DW-1:0] absd_s1 [2];
	logic signed [DW-1:0] lma_s1 [2];
	logic signed [DW-1:0] hma_s1 [2];
	logic signed [DW-1:0] aml_s1 [2];
	logic signed [DW-1:0] hml_s1 [2];
	logic signed [DW-1:0] edge_s1 [2];

	// Stage 2 registers.
	logic                 ia_s2, ib_s2;
	logic                 ok_s2 [4];
	logic signed [DW-1:0] n_s2 [4];
	logic signed [DW-1:0] den_s2 [4];
	logic signed [PW-1:0] p1_s2 [4];
	logic signed [PW-1:0] p2_s2 [4];
	logic signed [PW-1:0] p3_s2 [4];
	logic signed [PW-1:0] pxy_s2, pyx_s2;
	logic signed [DW-1:0] edge_s2 [2];
	logic signed [DW-1:0] absd_s2 [2];
	logic signed [DW-1:0] hml_s2 [2];

	// Stage 1 logic.
	logic                 ia_c, ib_c;
	logic signed [DW-1:0] delta_c [2];
	logic signed [DW-1:0] absd_c [2];
	logic signed [DW-1:0] edge_c [2];

	always_comb begin
		ia_c = 1'b1;
		ib_c = 1'b1;
		for (int k = 0; k < 2; k++) begin
			ia_c = ia_c && (pa[k] >= plo[k]) && (pa[k] <= phi[k]);
			ib_c = ib_c && (pb[k] >= plo[k]) && (pb[k] <= phi[k]);
			delta_c[k] = sbof_pkg::sx(pb[k]) - sbof_pkg::sx(pa[k]);
			absd_c[k]  = delta_c[k][DW-1] ? -delta_c[k] : delta_c[k];
			// Distance from the inside end to the edge facing the outside end.
			if (ia_c) begin
				edge_c[k] = (delta_c[k] > 0) ? sbof_pkg::sx(phi[k]) - sbof_pkg::sx(pa[k])
				                             : sbof_pkg::sx(pa[k]) - sbof_pkg::sx(plo[k]);
			end else begin
				edge_c[k] = (delta_c[k] < 0) ? sbof_pkg::sx(phi[k]) - sbof_pkg::sx(pb[k])
				                             : sbof_pkg::sx(pb[k]) - sbof_pkg::sx(plo[k]);
			end
		end
		// ia_c is complete only after both axes; recompute edges with the final flag.
		for (int k = 0; k < 2; k++) begin
			if (ia_c) begin
				edge_c[k] = (delta_c[k] > 0) ? sbof_pkg::sx(phi[k]) - sbof_pkg::sx(pa[k])
				                             : sbof_pkg::sx(pa[k]) - sbof_pkg::sx(plo[k]);
			end else begin
				edge_c[k] = (delta_c[k] < 0) ? sbof_pkg::sx(phi[k]) - sbof_pkg::sx(pb[k])
				                             : sbof_pkg::sx(pb[k]) - sbof_pkg::sx(plo[k]);
			end
		end
	end

	// Stage 2 logic.
	logic                 ok_c [4];
	logic signed [DW-1:0] n_c [4];
	logic signed [DW-1:0] n0_c [4];
	logic signed [DW-1:0] den_c [4];

	always_comb begin
		for (int e = 0; e < 4; e++) begin
			den_c[e] = absd_s1[e/2];
			n0_c[e]  = (e % 2 == 1) ? hma_s1[e/2] : lma_s1[e/2];
			n_c[e]   = delta_s1[e/2][DW-1] ? -n0_c[e] : n0_c[e];
			ok_c[e]  = (delta_s1[e/2] != '0) && (n_c[e] > 0) && (n_c[e] < den_c[e]);
		end
	end

	// Stage 3 logic.
	logic [3:0]           cut_c;
	logic signed [PW:0]   lo_side_c [4];
	logic signed [PW:0]   hi_side_c [4];
	logic                 selx_c;

	always_comb begin
		for (int e = 0; e < 4; e++) begin
			lo_side_c[e] = sbof_pkg::sxp(p1_s2[e]) + sbof_pkg::sxp(p2_s2[e]);
			hi_side_c[e] = sbof_pkg::sxp(p3_s2[e]) - sbof_pkg::sxp(p2_s2[e]);
			cut_c[e]     = ok_s2[e] && (lo_side_c[e] > 0) && (hi_side_c[e] > 0);
		end
		if (absd_s2[1] == '0) begin
			selx_c = 1'b1;
		end else if (absd_s2[0] == '0) begin
			selx_c = 1'b0;
		end else begin
			selx_c = (pxy_s2 <= pyx_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			vout <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
			vout <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ia_s1 <= ia_c;
			ib_s1 <= ib_c;
			for (int k = 0; k < 2; k++) begin
				delta_s1[k] <= delta_c[k];
				absd_s1[k]  <= absd_c[k];
				lma_s1[k]   <= sbof_pkg::sx(plo[k]) - sbof_pkg::sx(pa[k]);
				hma_s1[k]   <= sbof_pkg::sx(phi[k]) - sbof_pkg::sx(pa[k]);
				aml_s1[k]   <= sbof_pkg::sx(pa[k]) - sbof_pkg::sx(plo[k]);
				hml_s1[k]   <= sbof_pkg::sx(phi[k]) - sbof_pkg::sx(plo[k]);
				edge_s1[k]  <= edge_c[k];
			end

			ia_s2 <= ia_s1;
			ib_s2 <= ib_s1;
			for (int e = 0; e < 4; e++) begin
				ok_s2[e]  <= ok_c[e];
				n_s2[e]   <= n_c[e];
				den_s2[e] <= den_c[e];
				p1_s2[e]  <= aml_s1[1 - e/2] * den_c[e];
				p2_s2[e]  <= n_c[e] * delta_s1[1 - e/2];
				p3_s2[e]  <= hma_s1[1 - e/2] * den_c[e];
			end
			pxy_s2 <= edge_s1[0] * absd_s1[1];
			pyx_s2 <= edge_s1[1] * absd_s1[0];
			for (int k = 0; k < 2; k++) begin
				edge_s2[k] <= edge_s1[k];
				absd_s2[k] <= absd_s1[k];
				hml_s2[k]  <= hml_s1[k];
			end

			fr.ia      <= ia_s2;
			fr.ib      <= ib_s2;
			fr.cut     <= cut_c;
			for (int e = 0; e < 4; e++) begin
				fr.cn[e] <= n_s2[e];
				fr.cd[e] <= den_s2[e];
			end
			fr.one_num <= selx_c ? edge_s2[0] : edge_s2[1];
			fr.one_den <= selx_c ? absd_s2[0] : absd_s2[1];
			for (int k = 0; k < 2; k++) begin
				fr.hml[k]  <= hml_s2[k];
				fr.absd[k] <= absd_s2[k];
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/sbof_select.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbof_select
// Two stages: picks the case and forms the numerator and denominator.
// ----------------------------------------------------------------------------
module sbof_select (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              vin,
	input  wire sbof_pkg::front_t  fr,
	output logic                   vout,
	output sbof_pkg::div_t         job
);

	localparam int CW = sbof_pkg::COORD_WIDTH;
	localparam int DW = sbof_pkg::DW;
	localparam int NW = sbof_pkg::NW;

	logic              v_s4;
	sbof_pkg::kind_t   kind_s4;
	logic              adj_s4;
	logic [NW-1:0]     num_s4, den_s4;
	logic [NW-1:0]     ph_s4, pv_s4, pd_s4;

	logic [2:0]        ncut_c;
	logic              oppx_c, oppy_c;
	sbof_pkg::kind_t   kind_c;
	logic              adj_c;
	logic [NW-1:0]     num_c, den_c;
	logic [DW-1:0]     nh_c, dh_c, nv_c, dv_c;

	always_comb begin
		ncut_c = 3'(fr.cut[0]) + 3'(fr.cut[1]) + 3'(fr.cut[2]) + 3'(fr.cut[3]);
		oppx_c = fr.cut[0] & fr.cut[1];
		oppy_c = fr.cut[2] & fr.cut[3];
		nh_c   = fr.cut[3] ? fr.cn[3] : fr.cn[2];
		dh_c   = fr.cut[3] ? fr.cd[3] : fr.cd[2];
		nv_c   = fr.cut[1] ? fr.cn[1] : fr.cn[0];
		dv_c   = fr.cut[1] ? fr.cd[1] : fr.cd[0];
		adj_c  = 1'b0;
		num_c  = '0;
		den_c  = '0;
		if (fr.ia && fr.ib) begin
			kind_c = sbof_pkg::K_ONE;
		end else if (fr.ia ^ fr.ib) begin
			kind_c = sbof_pkg::K_DIV;
			num_c  = {{(NW-CW){1'b0}}, fr.one_num[CW-1:0]};
			den_c  = {{(NW-CW){1'b0}}, fr.one_den[CW-1:0]};
		end else if (ncut_c < 3'd2) begin
			kind_c = sbof_pkg::K_ZERO;
		end else if (oppy_c) begin
			// An inverted side has a negative length and yields zero.
			kind_c = fr.hml[1][DW-1] ? sbof_pkg::K_ZERO : sbof_pkg::K_DIV;
			num_c  = {{(NW-CW){1'b0}}, fr.hml[1][CW-1:0]};
			den_c  = {{(NW-CW){1'b0}}, fr.absd[1][CW-1:0]};
		end else if (oppx_c) begin
			kind_c = fr.hml[0][DW-1] ? sbof_pkg::K_ZERO : sbof_pkg::K_DIV;
			num_c  = {{(NW-CW){1'b0}}, fr.hml[0][CW-1:0]};
			den_c  = {{(NW-CW){1'b0}}, fr.absd[0][CW-1:0]};
		end else begin
			// Adjacent edges: difference of the two crossing parameters.
			kind_c = sbof_pkg::K_DIV;
			adj_c  = 1'b1;
		end
	end

	logic signed [NW:0] diff_c;
	logic [NW-1:0]      absdiff_c;

	always_comb begin
		diff_c    = $signed({1'b0, ph_s4}) - $signed({1'b0, pv_s4});
		absdiff_c = diff_c[NW] ? NW'(-diff_c) : diff_c[NW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			vout <= 1'b0;
		end else if (en) begin
			v_s4 <= vin;
			vout <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s4 <= kind_c;
			adj_s4  <= adj_c;
			num_s4  <= num_c;
			den_s4  <= den_c;
			ph_s4   <= nh_c[CW-1:0] * dv_c[CW-1:0];
			pv_s4   <= nv_c[CW-1:0] * dh_c[CW-1:0];
			pd_s4   <= dh_c[CW-1:0] * dv_c[CW-1:0];

			job.kind <= kind_s4;
			job.num  <= adj_s4 ? absdiff_c : num_s4;
			job.den  <= adj_s4 ? pd_s4 : den_s4;
		end
	end

endmodule
`default_nettype wire

// File: sv/sbof_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbof_div
// Pipelined restoring divider, one quotient bit per stage, saturating at one.
// ----------------------------------------------------------------------------
module sbof_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     vin,
	input  wire sbof_pkg::div_t           job,
	output logic                          vout,
	output logic [sbof_pkg::QW-1:0]       res
);

	localparam int FB = sbof_pkg::FRAC_BITS;
	localparam int NW = sbof_pkg::NW;

	logic              v_s [FB+1];
	sbof_pkg::kind_t   kind_s [FB+1];
	logic [NW-1:0]     rem_s [FB+1];
	logic [NW-1:0]     den_s [FB+1];
	logic [FB-1:0]     q_s [FB+1];

	sbof_pkg::kind_t   kind0_c;
	logic [NW:0]       t_c [FB];
	logic              ge_c [FB];

	always_comb begin
		kind0_c = job.kind;
		if (job.kind == sbof_pkg::K_DIV) begin
			if (job.den == '0) begin
				kind0_c = sbof_pkg::K_ZERO;
			end else if (job.num >= job.den) begin
				kind0_c = sbof_pkg::K_ONE;
			end
		end
		for (int i = 0; i < FB; i++) begin
			t_c[i]  = {rem_s[i], 1'b0};
			ge_c[i] = (t_c[i] >= {1'b0, den_s[i]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= FB; i++) begin
				v_s[i] <= 1'b0;
			end
		end else if (en) begin
			v_s[0] <= vin;
			for (int i = 0; i < FB; i++) begin
				v_s[i+1] <= v_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s[0] <= kind0_c;
			rem_s[0]  <= job.num;
			den_s[0]  <= job.den;
			q_s[0]    <= '0;
			for (int i = 0; i < FB; i++) begin
				kind_s[i+1] <= kind_s[i];
				den_s[i+1]  <= den_s[i];
				rem_s[i+1]  <= ge_c[i] ? NW'(t_c[i] - {1'b0, den_s[i]}) : t_c[i][NW-1:0];
				q_s[i+1]    <= {q_s[i][FB-2:0], ge_c[i]};
			end
		end
	end

	assign vout = v_s[FB];

	always_comb begin
		case (kind_s[FB])
			sbof_pkg::K_ONE: res = sbof_pkg::ONE_Q;
			sbof_pkg::K_DIV: res = {1'b0, q_s[FB]};
			default:         res = '0;
		endcase
	end

endmodule
`default_nettype wire

// File: sv/segment_box_overlap_fraction_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segment_box_overlap_fraction_unit
// Fraction of a line segment that lies inside a closed axis-aligned box.
// ----------------------------------------------------------------------------
// The unit takes one word per cycle, each holding a segment A-B and a box
// given by its lower-left and upper-right corners, all signed Q8.16, and
// returns for each word the part of the segment inside the box as unsigned
// Q1.16, truncated, where 65536 stands for the whole segment. Points on the
// boundary count as inside. The pipeline is 23 stages deep: three stages of
// geometry (differences, edge products, crossing tests), two of case
// selection and operand forming, one divider entry stage, sixteen stages of
// the restoring divider (one quotient bit each) and the output register. A
// new word can enter on every clock; a stall on the output holds the whole
// pipeline in place, so the accept rate is one word per cycle while the
// output side takes one word per cycle.
// ----------------------------------------------------------------------------
module segment_box_overlap_fraction_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// Fields from bit 0 up: ax, ay, bx, by, low_x, low_y, up_x, up_y.
	input  wire logic [sbof_pkg::IN_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// Fields from bit 0 up: fraction, then zero fill.
	output logic [sbof_pkg::OUT_W-1:0]       m_tdata
);

	localparam int QW = sbof_pkg::QW;

	// The whole pipeline moves as one: it advances whenever the output
	// register is empty or its word is being taken.
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic              fr_valid;
	sbof_pkg::front_t  fr;
	logic              job_valid;
	sbof_pkg::div_t    job;
	logic              res_valid;
	logic [QW-1:0]     res;
	logic [QW-1:0]     fraction_q;

	sbof_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vin    (s_tvalid),
		.data   (s_tdata),
		.vout   (fr_valid),
		.fr     (fr)
	);

	sbof_select u_select (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vin    (fr_valid),
		.fr     (fr),
		.vout   (job_valid),
		.job    (job)
	);

	sbof_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vin    (job_valid),
		.job    (job),
		.vout   (res_valid),
		.res    (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fraction_q <= res;
		end
	end

	assign m_tdata = {{(sbof_pkg::OUT_W-QW){1'b0}}, fraction_q};

endmodule
`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the segment / box overlap fraction unit.
// ----------------------------------------------------------------------------
// Segments and boxes go in as stream words. A behavioral model computes the
// expected inside fraction with exact integer geometry. A small scoreboard
// holds the expected fractions in order and compares each output word with
// the oldest one. Both sides idle at random in the first two of three phases.
// Two stretches hold the output off for a long time so that the pipeline fills up.
// ----------------------------------------------------------------------------
module tb;
	import sbof_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int ONEF = 1 << FRAC_BITS;

	// Truncated num/den in Q1.16, saturated at one; a negative length gives zero.
	function automatic longint frac_q(longint num, longint den);
		longint q;
		q = 0;
		if (den <= 0 || num < 0) return 0;
		if (num >= den) return ONEF;
		for (int i = 0; i < FRAC_BITS; i++) begin
			num = num << 1;
			q = q << 1;
			if (num >= den) begin
				num = num - den;
				q = q | 1;
			end
		end
		return q;
	endfunction

	function automatic longint overlap_fraction(logic [IN_W-1:0] w);
		longint a[2], b[2], lo[2], hi[2];
		longint cn[2][2], cd[2][2];
		bit cut[2][2];
		bit ia, ib, any;
		longint res, den, n, sd, ext, nh, dh, nv, dv, v, edg, q;
		int ncut, opp, o;
		a[0] = $signed(w[0*CW +: CW]);
		a[1] = $signed(w[1*CW +: CW]);
		b[0] = $signed(w[2*CW +: CW]);
		b[1] = $signed(w[3*CW +: CW]);
		lo[0] = $signed(w[4*CW +: CW]);
		lo[1] = $signed(w[5*CW +: CW]);
		hi[0] = $signed(w[6*CW +: CW]);
		hi[1] = $signed(w[7*CW +: CW]);
		ia = a[0] >= lo[0] && a[1] >= lo[1] && a[0] <= hi[0] && a[1] <= hi[1];
		ib = b[0] >= lo[0] && b[1] >= lo[1] && b[0] <= hi[0] && b[1] <= hi[1];
		res = 0;
		if (ia && ib) begin
			res = ONEF;
		end else if (!ia && !ib) begin
			ncut = 0;
			opp = -1;
			for (int d = 0; d < 2; d++) begin
				o = 1 - d;
				for (int s = 0; s < 2; s++) begin
					den = b[d] - a[d];
					n = (s == 0 ? lo[d] : hi[d]) - a[d];
					sd = b[o] - a[o];
					cut[d][s] = 0;
					cn[d][s] = 0;
					cd[d][s] = 1;
					if (den == 0) continue;
					if (den < 0) begin
						den = -den;
						n = -n;
					end
					if (!(n > 0 && n < den)) continue;
					// Products stay below 2^51, so 64-bit math is exact here.
					if ((a[o] - lo[o]) * den + n * sd > 0 &&
					    (hi[o] - a[o]) * den - n * sd > 0) begin
						cut[d][s] = 1;
						cn[d][s] = n;
						cd[d][s] = den;
						ncut++;
					end
				end
			end
			if (ncut >= 2) begin
				for (int d = 0; d < 2; d++)
					if (cut[d][0] && cut[d][1]) opp = d;
				if (opp >= 0) begin
					ext = a[opp] - b[opp];
					if (ext < 0) ext = -ext;
					res = frac_q(hi[opp] - lo[opp], ext);
				end else begin
					nh = 0; dh = 1; nv = 0; dv = 1;
					for (int s = 0; s < 2; s++) begin
						if (cut[1][s]) begin
							nh = cn[1][s];
							dh = cd[1][s];
						end
						if (cut[0][s]) begin
							nv = cn[0][s];
							dv = cd[0][s];
						end
					end
					v = nh * dv - nv * dh;
					if (v < 0) v = -v;
					res = frac_q(v, dh * dv);
				end
			end
		end else begin
			any = 0;
			for (int d = 0; d < 2; d++) begin
				v = ia ? b[d] - a[d] : a[d] - b[d];
				if (v == 0) continue;
				if (ia) edg = (v > 0) ? hi[d] - a[d] : a[d] - lo[d];
				else edg = (v > 0) ? hi[d] - b[d] : b[d] - lo[d];
				q = (edg < 0) ? 0 : frac_q(edg, v < 0 ? -v : v);
				if (!any || q < res) res = q;
				any = 1;
			end
		end
		return res;
	endfunction

	// Expected fractions, oldest first.
	class fraction_board;
		longint pending[$];
		int errors;
		int checked;

		function void note_segment(logic [IN_W-1:0] w);
			pending.insert(pending.size(), overlap_fraction(w));
		endfunction

		function void check_fraction(logic [OUT_W-1:0] got);
			longint want;
			checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %0d", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got != OUT_W'(want)) begin
				$display("%0t: fraction mismatch, expected %0d, actual %0d",
					$time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	// Fields from bit 0 up: ax, ay, bx, by, low_x, low_y, up_x, up_y.
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	// Fields from bit 0 up: fraction, then zero fill.
	logic [OUT_W-1:0] m_tdata;

	fraction_board board = new();
	int src_idle = 0;    // percent of cycles the sender idles
	int sink_idle = 0;   // percent of cycles the receiver idles
	bit sink_hold = 0;   // long hold-off requested
	int n_sent = 0;

	always #5 clk = ~clk;

	segment_box_overlap_fraction_unit dut (.*);

	// Receiver: random idling, and a long hold-off counted here.
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) board.check_fraction(m_tdata);
			if (sink_hold && hold == 0) hold = 200;
			if (hold > 0) begin
				hold--;
				if (hold == 0) sink_hold = 0;
				m_tready <= 0;
			end else begin
				m_tready <= arst_n && ($urandom_range(99) >= sink_idle);
			end
		end
	end

	// One word, held until the unit takes it. Valid stays high between
	// words unless the sender idles.
	task automatic send_word(logic [IN_W-1:0] w);
		if ($urandom_range(99) < src_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < src_idle) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= w;
		board.note_segment(w);
		n_sent++;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	function automatic logic [IN_W-1:0] pack_word(longint ax, longint ay, longint bx,
		longint by, longint lx, longint ly, longint ux, longint uy);
		return {CW'(uy), CW'(ux), CW'(ly), CW'(lx), CW'(by), CW'(bx), CW'(ay), CW'(ax)};
	endfunction

	// Random coordinate: mostly near a small box, sometimes anywhere.
	function automatic longint rnd_coord(int mode);
		if (mode == 0) return $signed(CW'($urandom));
		if (mode == 1) return longint'($urandom_range(0, 4000)) - 2000;
		return longint'($urandom_range(0, 40)) * 100 - 2000;
	endfunction

	task automatic send_random();
		int mode;
		longint lx, ly, ux, uy, t;
		mode = $urandom_range(0, 9);
		mode = (mode == 0) ? 0 : (mode < 6 ? 1 : 2);
		lx = rnd_coord(mode); ly = rnd_coord(mode);
		ux = rnd_coord(mode); uy = rnd_coord(mode);
		// Mostly well-formed boxes; a few are left inverted.
		if ($urandom_range(9) != 0) begin
			if (lx > ux) begin t = lx; lx = ux; ux = t; end
			if (ly > uy) begin t = ly; ly = uy; uy = t; end
		end
		send_word(pack_word(rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
			rnd_coord(mode), lx, ly, ux, uy));
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	localparam longint MX = (1 <<< (CW - 1)) - 1;
	localparam longint MN = -(1 <<< (CW - 1));

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: both ends inside, boundary points, degenerate segments.
		send_word(pack_word(10, 10, 20, 20, 0, 0, 100, 100));
		send_word(pack_word(0, 0, 100, 100, 0, 0, 100, 100));
		send_word(pack_word(50, 50, 50, 50, 0, 0, 100, 100));
		send_word(pack_word(150, 50, 150, 50, 0, 0, 100, 100));
		// One end inside, including an axis with zero extent.
		send_word(pack_word(50, 50, 150, 50, 0, 0, 100, 100));
		send_word(pack_word(50, 50, 150, 250, 0, 0, 100, 100));
		send_word(pack_word(50, 50, -50, -30, 0, 0, 100, 100));
		// Both ends outside: opposite sides on x, on y, and on x along a diagonal.
		send_word(pack_word(-100, 50, 200, 50, 0, 0, 100, 100));
		send_word(pack_word(50, -100, 60, 200, 0, 0, 100, 100));
		send_word(pack_word(-50, -40, 150, 140, 0, 0, 100, 100));
		// Adjacent sides, a line through two corners, no crossing.
		send_word(pack_word(-20, 50, 50, 120, 0, 0, 100, 100));
		send_word(pack_word(-50, -50, 150, 150, 0, 0, 100, 100));
		send_word(pack_word(-50, 200, 200, 300, 0, 0, 100, 100));
		// Parallel to an edge, lying on it.
		send_word(pack_word(-50, 0, 150, 0, 0, 0, 100, 100));
		// Inverted box.
		send_word(pack_word(-50, 50, 150, 50, 100, 0, 0, 100));
		// Field extremes.
		send_word(pack_word(MN, MN, MX, MX, MN, MN, MX, MX));
		send_word(pack_word(MN, MX, MX, MN, MN + 1, MN + 1, MX - 1, MX - 1));
		send_word(pack_word(MN, 0, MX, 0, -1, MN, 0, MX));
		send_word(pack_word(MX, MX, MN, MN, 0, 0, 0, 0));
		send_word(pack_word(-1, -1, -1, -1, -1, -1, -1, -1));
		drain();

		// Three idling phases.
		src_idle = 12; sink_idle = 66;
		for (int i = 0; i < 530; i++) begin
			if (i == 100) sink_hold = 1;
			send_random();
		end
		drain();
		src_idle = 66; sink_idle = 12;
		for (int i = 0; i < 530; i++) send_random();
		src_idle = 0; sink_idle = 0;
		for (int i = 0; i < 540; i++) begin
			if (i == 300) begin
				sink_hold = 1;
			end
			send_random();
		end
		drain();
		repeat (40) @(posedge clk);
		$display("Sent %0d segment words and checked %0d fractions over three idling phases.",
			n_sent, board.checked);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#5ms;
		$display("Timeout with %0d fractions outstanding", board.pending.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

// File: filelist.f
sv/sbof_pkg.sv
sv/sbof_front.sv
sv/sbof_select.sv
sv/sbof_div.sv
sv/segment_box_overlap_fraction_unit.sv
verif/tb.sv
